// ----- design/abst_pkg.sv -----
`default_nettype none

package abst_pkg;

    // Table geometry
    localparam int TABLE_SIZE = 127;
    localparam int KEY_W      = 32;
    localparam int IDX_W      = $clog2(TABLE_SIZE);
    // The walk index must hold 2i+2 for the last slot so that overflow is seen.
    localparam int WALK_W     = $clog2(2 * TABLE_SIZE + 3);
    localparam int SLOT_W     = 7;
    localparam int STATUS_W   = 3;

    // Request modes
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_SEARCH = 1'b1;

    // Result codes
    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 3'd0,
        ST_FULL      = 3'd1,
        ST_FOUND     = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_ZERO_KEY  = 3'd4
    } status_t;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_HOLD
    } state_t;

endpackage

`default_nettype wire

// ----- design/abst_if.sv -----
`default_nettype none

// Request channel: one insert or search request.
interface abst_req_if;
    logic                             valid;
    logic                             ready;
    logic                             mode;
    logic signed [abst_pkg::KEY_W-1:0] key;

    modport source (output valid, output mode, output key, input ready);
    modport sink   (input valid, input mode, input key, output ready);
endinterface

// Result channel: one status and slot per request.
interface abst_res_if;
    logic                          valid;
    logic                          ready;
    abst_pkg::status_t             status;
    logic [abst_pkg::SLOT_W-1:0]   slot_index;

    modport source (output valid, output status, output slot_index, input ready);
    modport sink   (input valid, input status, input slot_index, output ready);
endinterface

`default_nettype wire

// ----- design/array_bst_insert_search_core.sv -----
// Operation: a request visits one tree level per cycle (at most seven for 127 slots),
// then passes through the result stage (S_HOLD) into the output register; a zero-key
// request goes from acceptance straight to the result stage.
// Ordering: one request at a time, as the walk, the result stage and the return to idle
// do not overlap; a stalled result keeps the sequencer waiting in the result stage.
// Reset: the per-slot valid flags clear at once, so every slot reads as empty.
`default_nettype none

module array_bst_insert_search_core (
    input  wire logic   clk,
    input  wire logic   rst_n,
    abst_req_if.sink    req,
    abst_res_if.source  res
);

    logic [abst_pkg::TABLE_SIZE-1:0]  valid_reg;
    logic                             valid_q_reg;
    abst_pkg::state_t                 state_reg, state_next;
    logic [abst_pkg::WALK_W-1:0]      idx_reg, idx_next;
    logic                             mode_reg, mode_next;
    logic signed [abst_pkg::KEY_W-1:0] key_reg, key_next;
    abst_pkg::status_t                pend_status_reg, pend_status_next;
    logic [abst_pkg::SLOT_W-1:0]      pend_slot_reg, pend_slot_next;
    logic                             out_valid_reg, out_valid_next;
    abst_pkg::status_t                out_status_reg, out_status_next;
    logic [abst_pkg::SLOT_W-1:0]      out_slot_reg, out_slot_next;

    logic                             ram_we;
    logic [abst_pkg::IDX_W-1:0]       ram_waddr;
    logic [abst_pkg::IDX_W-1:0]       ram_raddr;
    logic [abst_pkg::KEY_W-1:0]       ram_rdata;
    logic signed [abst_pkg::KEY_W-1:0] node;
    logic [abst_pkg::WALK_W-1:0]      child;

    // Node store
    abst_ram #(
        .WIDTH (abst_pkg::KEY_W),
        .DEPTH (abst_pkg::TABLE_SIZE)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (key_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // A slot never written reads as empty.
    assign node = valid_q_reg ? $signed(ram_rdata) : '0;

    // Child of the current slot on the walk direction.
    assign child = (key_reg <= node) ? ((idx_reg << 1) + abst_pkg::WALK_W'(1))
                                     : ((idx_reg << 1) + abst_pkg::WALK_W'(2));

    assign req.ready      = (state_reg == abst_pkg::S_IDLE);
    assign res.valid      = out_valid_reg;
    assign res.status     = out_status_reg;
    assign res.slot_index = out_slot_reg;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= abst_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
            valid_reg     <= '0;
            valid_q_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            valid_q_reg   <= valid_reg[ram_raddr];
            if (ram_we)
            begin
                valid_reg[ram_waddr] <= 1'b1;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        idx_reg         <= idx_next;
        mode_reg        <= mode_next;
        key_reg         <= key_next;
        pend_status_reg <= pend_status_next;
        pend_slot_reg   <= pend_slot_next;
        out_status_reg  <= out_status_next;
        out_slot_reg    <= out_slot_next;
    end

    // Sequencer: next state and outputs
    always_comb
    begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        mode_next        = mode_reg;
        key_next         = key_reg;
        pend_status_next = pend_status_reg;
        pend_slot_next   = pend_slot_reg;
        out_valid_next   = out_valid_reg;
        out_status_next  = out_status_reg;
        out_slot_next    = out_slot_reg;
        ram_we           = 1'b0;
        ram_waddr        = abst_pkg::IDX_W'(idx_reg);
        ram_raddr        = '0;

        // The result register empties when the result is taken.
        if (res.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            abst_pkg::S_IDLE:
            begin
                // The root is read at the acceptance edge.
                if (req.valid)
                begin
                    mode_next = req.mode;
                    key_next  = req.key;
                    idx_next  = '0;
                    if (req.key == '0)
                    begin
                        pend_status_next = abst_pkg::ST_ZERO_KEY;
                        pend_slot_next   = '0;
                        state_next       = abst_pkg::S_HOLD;
                    end
                    else
                    begin
                        state_next = abst_pkg::S_WALK;
                    end
                end
            end

            abst_pkg::S_WALK:
            begin
                pend_slot_next = '0;
                if (node == '0)
                begin
                    // Empty slot ends the walk.
                    if (mode_reg == abst_pkg::MODE_INSERT)
                    begin
                        ram_we           = 1'b1;
                        pend_status_next = abst_pkg::ST_INSERTED;
                        pend_slot_next   = abst_pkg::SLOT_W'(idx_reg);
                    end
                    else
                    begin
                        pend_status_next = abst_pkg::ST_NOT_FOUND;
                    end
                    state_next = abst_pkg::S_HOLD;
                end
                else if (mode_reg == abst_pkg::MODE_SEARCH && node == key_reg)
                begin
                    pend_status_next = abst_pkg::ST_FOUND;
                    pend_slot_next   = abst_pkg::SLOT_W'(idx_reg);
                    state_next       = abst_pkg::S_HOLD;
                end
                else if (child >= abst_pkg::WALK_W'(abst_pkg::TABLE_SIZE))
                begin
                    // The walk has left the table.
                    pend_status_next = (mode_reg == abst_pkg::MODE_INSERT)
                                       ? abst_pkg::ST_FULL : abst_pkg::ST_NOT_FOUND;
                    state_next       = abst_pkg::S_HOLD;
                end
                else
                begin
                    idx_next  = child;
                    ram_raddr = abst_pkg::IDX_W'(child);
                end
            end

            abst_pkg::S_HOLD:
            begin
                // Wait until the result register is free.
                if (!out_valid_reg || res.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = pend_status_reg;
                    out_slot_next   = pend_slot_reg;
                    state_next      = abst_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = abst_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- design/abst_ram.sv -----
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data.
module abst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire
